@@ sv/pfs_pkg.sv @@
package pfs_pkg;

    localparam int ADDR_BITS     = 48;
    localparam int PAGE_SHIFT    = 12;
    localparam int FRAME_W       = ADDR_BITS - PAGE_SHIFT;
    localparam int MAX_PAGES_DEF = 4096;
    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 3;
    localparam int CFG_IDX_W     = 1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_REBUILD = 2'd2,
        ACT_RSVD    = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_OOM       = 3'd1,
        ST_ZERO      = 3'd2,
        ST_UNALIGNED = 3'd3,
        ST_RANGE     = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_START = 1'd0,
        CFG_REGION_SIZE  = 1'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_PUSH,
        S_REB_SUB,
        S_REB_SET,
        S_DONE
    } t_state;

endpackage

@@ sv/pfs_ram.sv @@
module pfs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    i_clk,
    i_we,
    i_waddr,
    i_wdata,
    i_re,
    i_raddr,
    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             i_clk;
    input  logic             i_we;
    input  logic [AW-1:0]    i_waddr;
    input  logic [WIDTH-1:0] i_wdata;
    input  logic             i_re;
    input  logic [AW-1:0]    i_raddr;
    output logic [WIDTH-1:0] o_rdata;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/page_frame_free_stack.sv @@
// One request at a time: a new one is taken only in S_IDLE, and each walks a
// fixed state sequence to S_DONE: alloc via S_EXEC and S_POP, free via S_EXEC
// and S_PUSH, rebuild via S_EXEC, S_REB_SUB and S_REB_SET, an alloc on an empty
// stack and the unused action code via S_EXEC only; S_DONE waits for the output.
// Reset (synchronous, active low) empties the stack, clears the counts, base
// frame and region registers; the stack memory itself is not cleared.
module page_frame_free_stack #(
    parameter int MAX_PAGES = pfs_pkg::MAX_PAGES_DEF,
    parameter int IDX_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
    parameter int CNT_W     = $clog2(MAX_PAGES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pfs_pkg::ADDR_BITS-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pfs_pkg::ACTION_W-1:0]  i_action,
    input  logic [pfs_pkg::ADDR_BITS-1:0] i_free_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pfs_pkg::STATUS_W-1:0]  o_status,
    output logic [pfs_pkg::ADDR_BITS-1:0] o_page_address,
    output logic [CNT_W-1:0]              o_free_count,
    output logic [CNT_W-1:0]              o_total_count
);
    import pfs_pkg::*;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_depth, n_depth;
    logic [CNT_W-1:0]     r_managed, n_managed;
    logic [CNT_W-1:0]     r_ident, n_ident;
    logic [FRAME_W-1:0]   r_base, n_base;
    logic                 r_out_valid, n_out_valid;
    logic [ADDR_BITS-1:0] r_region_start, r_region_size;

    t_action              r_action, n_action;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [FRAME_W-1:0]   r_sf, n_sf;
    logic [FRAME_W-1:0]   r_ef, n_ef;
    logic [FRAME_W-1:0]   r_diff, n_diff;
    logic                 r_gt, n_gt;
    logic                 r_chk_zero, n_chk_zero;
    logic                 r_chk_unal, n_chk_unal;
    logic                 r_chk_lt, n_chk_lt;
    logic                 r_pop_ident, n_pop_ident;
    logic [IDX_W-1:0]     r_pop_idx, n_pop_idx;
    t_status              r_res_status, n_res_status;
    logic [ADDR_BITS-1:0] r_res_page, n_res_page;
    t_status              r_status, n_status;
    logic [ADDR_BITS-1:0] r_page, n_page;
    logic [CNT_W-1:0]     r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0]     r_total_cnt, n_total_cnt;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [IDX_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [IDX_W-1:0]     ram_rdata;

    logic                 out_free;
    logic [CNT_W-1:0]     depth_dec;
    logic [IDX_W-1:0]     pop_idx;
    logic [ADDR_BITS-1:0] start_sum;
    logic [ADDR_BITS-1:0] end_sum;

    pfs_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_PAGES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_page_address = r_page;
    assign o_free_count   = r_free_cnt;
    assign o_total_count  = r_total_cnt;

    assign out_free  = !r_out_valid || i_out_ready;
    assign depth_dec = r_depth - CNT_W'(1);
    assign pop_idx   = r_pop_ident ? r_pop_idx : ram_rdata;
    assign start_sum = r_region_start + ADDR_BITS'((1 << PAGE_SHIFT) - 1);
    assign end_sum   = r_region_start + r_region_size;

    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_managed    = r_managed;
        n_ident      = r_ident;
        n_base       = r_base;
        n_action     = r_action;
        n_addr       = r_addr;
        n_sf         = r_sf;
        n_ef         = r_ef;
        n_diff       = r_diff;
        n_gt         = r_gt;
        n_chk_zero   = r_chk_zero;
        n_chk_unal   = r_chk_unal;
        n_chk_lt     = r_chk_lt;
        n_pop_ident  = r_pop_ident;
        n_pop_idx    = r_pop_idx;
        n_res_status = r_res_status;
        n_res_page   = r_res_page;
        n_status     = r_status;
        n_page       = r_page;
        n_free_cnt   = r_free_cnt;
        n_total_cnt  = r_total_cnt;
        n_out_valid  = r_out_valid && !i_out_ready;
        ram_we       = 1'b0;
        ram_waddr    = r_depth[IDX_W-1:0];
        ram_wdata    = r_diff[IDX_W-1:0];
        ram_re       = 1'b0;
        ram_raddr    = depth_dec[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action = t_action'(i_action);
                    n_addr   = i_free_address;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status = ST_OK;
                n_res_page   = '0;
                unique case (r_action)
                    ACT_ALLOC: begin
                        if (r_depth == '0) begin
                            n_res_status = ST_OOM;
                            n_state      = S_DONE;
                        end else begin
                            n_depth     = depth_dec;
                            ram_re      = 1'b1;
                            n_pop_ident = (depth_dec < r_ident);
                            n_pop_idx   = depth_dec[IDX_W-1:0];
                            if (depth_dec < r_ident) begin
                                n_ident = depth_dec;
                            end
                            n_state = S_POP;
                        end
                    end
                    ACT_FREE: begin
                        n_chk_zero = (r_addr == '0);
                        n_chk_unal = (r_addr[PAGE_SHIFT-1:0] != '0);
                        n_chk_lt   = (r_addr[ADDR_BITS-1:PAGE_SHIFT] < r_base);
                        n_diff     = r_addr[ADDR_BITS-1:PAGE_SHIFT] - r_base;
                        n_state    = S_PUSH;
                    end
                    ACT_REBUILD: begin
                        n_sf    = start_sum[ADDR_BITS-1:PAGE_SHIFT];
                        n_ef    = end_sum[ADDR_BITS-1:PAGE_SHIFT];
                        n_state = S_REB_SUB;
                    end
                    ACT_RSVD: begin
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_POP: begin
                n_res_page = {r_base + FRAME_W'(pop_idx), {PAGE_SHIFT{1'b0}}};
                n_state    = S_DONE;
            end
            S_PUSH: begin
                priority if (r_chk_zero) begin
                    n_res_status = ST_ZERO;
                end else if (r_chk_unal) begin
                    n_res_status = ST_UNALIGNED;
                end else if (r_chk_lt || (r_diff >= FRAME_W'(r_managed))) begin
                    n_res_status = ST_RANGE;
                end else if (r_depth >= CNT_W'(MAX_PAGES)) begin
                    n_res_status = ST_FULL;
                end else begin
                    ram_we  = 1'b1;
                    n_depth = r_depth + CNT_W'(1);
                end
                n_state = S_DONE;
            end
            S_REB_SUB: begin
                n_gt    = (r_ef > r_sf);
                n_diff  = r_ef - r_sf;
                n_state = S_REB_SET;
            end
            S_REB_SET: begin
                n_base = r_sf;
                if (!r_gt) begin
                    n_managed = '0;
                end else if (r_diff > FRAME_W'(MAX_PAGES)) begin
                    n_managed = CNT_W'(MAX_PAGES);
                end else begin
                    n_managed = r_diff[CNT_W-1:0];
                end
                n_depth = n_managed;
                n_ident = n_managed;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_page      = r_res_page;
                    n_free_cnt  = r_depth;
                    n_total_cnt = r_managed;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_depth        <= '0;
            r_managed      <= '0;
            r_ident        <= '0;
            r_base         <= '0;
            r_out_valid    <= 1'b0;
            r_region_start <= '0;
            r_region_size  <= '0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_managed   <= n_managed;
            r_ident     <= n_ident;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_REGION_START: r_region_start <= i_cfg_data;
                    CFG_REGION_SIZE:  r_region_size  <= i_cfg_data;
                    default:          r_region_size  <= r_region_size;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_addr       <= n_addr;
        r_sf         <= n_sf;
        r_ef         <= n_ef;
        r_diff       <= n_diff;
        r_gt         <= n_gt;
        r_chk_zero   <= n_chk_zero;
        r_chk_unal   <= n_chk_unal;
        r_chk_lt     <= n_chk_lt;
        r_pop_ident  <= n_pop_ident;
        r_pop_idx    <= n_pop_idx;
        r_res_status <= n_res_status;
        r_res_page   <= n_res_page;
        r_status     <= n_status;
        r_page       <= n_page;
        r_free_cnt   <= n_free_cnt;
        r_total_cnt  <= n_total_cnt;
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CNT_W'(MAX_PAGES))
        else $error("Free stack depth exceeds its capacity.");

    a_ident_below_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ident <= r_depth)
        else $error("Untouched stack prefix extends past the stack top.");

    a_page_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_status != ST_OK)) |-> (o_page_address == '0))
        else $error("A failed request returned a nonzero page address.");

    a_oom_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_status == ST_OOM)) |-> (o_free_count == '0))
        else $error("Out of memory reported while pages remain free.");

endmodule

@@ bench/page_frame_free_stack_tb.sv @@
module page_frame_free_stack_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfs_pkg::*;

    localparam int POOL_MAX    = MAX_PAGES_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        t_action     act;
        logic [47:0] addr;
    } t_request;

    typedef struct {
        t_status     status;
        logic [47:0] page;
        logic [12:0] free_cnt;
        logic [12:0] total_cnt;
    } t_reply;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index    = '0;
    logic [47:0] i_cfg_data     = '0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_action       = '0;
    logic [47:0] i_free_address = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [2:0]  o_status;
    logic [47:0] o_page_address;
    logic [12:0] o_free_count;
    logic [12:0] o_total_count;

    t_request    request_q[$];
    t_reply      reply_q[$];

    logic [11:0] frame_stack [0:POOL_MAX-1];
    int unsigned free_depth     = 0;
    int unsigned managed_cnt    = 0;
    logic [35:0] pool_base      = '0;
    logic [47:0] region_start_r = '0;
    logic [47:0] region_size_r  = '0;

    logic [35:0] gen_base  = '0;
    int unsigned gen_pages = 0;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        rx_hold        = 1'b0;
    int          mismatches     = 0;
    int          cycle_cnt      = 0;

    page_frame_free_stack u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_free_address (i_free_address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_page_address (o_page_address),
        .o_free_count   (o_free_count),
        .o_total_count  (o_total_count)
    );

    always #10ns i_clk = ~i_clk;

    function automatic void region_frames(input logic [47:0] rs, input logic [47:0] sz,
                                          output logic [35:0] base,
                                          output int unsigned pages);
        logic [47:0] a_lo;
        logic [47:0] a_hi;
        logic [47:0] span;
        a_lo  = (rs + 48'hFFF) & ~48'hFFF;
        a_hi  = (rs + sz) & ~48'hFFF;
        pages = 0;
        if (a_hi > a_lo) begin
            span  = (a_hi - a_lo) >> 12;
            pages = (span > 48'(POOL_MAX)) ? POOL_MAX : int'(span);
        end
        base = a_lo[47:12];
    endfunction

    task automatic allocator_step(input t_action act, input logic [47:0] addr);
        t_reply      r;
        logic [47:0] lo;
        logic [35:0] off;
        int          i;
        r.status = ST_OK;
        r.page   = '0;
        case (act)
            ACT_ALLOC: begin
                if (free_depth == 0) begin
                    r.status = ST_OOM;
                end else begin
                    free_depth--;
                    r.page = {pool_base + 36'(frame_stack[free_depth]), 12'h000};
                end
            end
            ACT_FREE: begin
                lo  = {pool_base, 12'h000};
                off = addr[47:12] - pool_base;
                if (addr == '0) begin
                    r.status = ST_ZERO;
                end else if (addr[11:0] != '0) begin
                    r.status = ST_UNALIGNED;
                end else if (addr < lo || off >= managed_cnt) begin
                    r.status = ST_RANGE;
                end else if (free_depth >= POOL_MAX) begin
                    r.status = ST_FULL;
                end else begin
                    frame_stack[free_depth] = off[11:0];
                    free_depth++;
                end
            end
            ACT_REBUILD: begin
                region_frames(region_start_r, region_size_r, pool_base, managed_cnt);
                for (i = 0; i < int'(managed_cnt); i++) begin
                    frame_stack[i] = 12'(i);
                end
                free_depth = managed_cnt;
            end
            default: ;
        endcase
        r.free_cnt  = 13'(free_depth);
        r.total_cnt = 13'(managed_cnt);
        reply_q.push_back(r);
    endtask

    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : driver
        t_request job;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                allocator_step(t_action'(i_action), i_free_address);
            end
            if (!i_in_valid || o_in_ready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    job = request_q.pop_front();
                    i_in_valid     <= 1'b1;
                    i_action       <= job.act;
                    i_free_address <= job.addr;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_reply want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: result beat with nothing outstanding, status 0x%0h",
                             $time, o_status);
                    mismatches++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", 64'(want.status), 64'(o_status));
                    check_field("page_address", 64'(want.page), 64'(o_page_address));
                    check_field("free_count", 64'(want.free_cnt), 64'(o_free_count));
                    check_field("total_count", 64'(want.total_cnt), 64'(o_total_count));
                end
            end
            i_out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("page_frame_free_stack_tb: errors");
            $finish;
        end
    end

    task automatic queue_job(input t_action act, input logic [47:0] addr);
        t_request job;
        if (act == ACT_REBUILD) begin
            region_frames(region_start_r, region_size_r, gen_base, gen_pages);
        end
        job.act  = act;
        job.addr = addr;
        request_q.push_back(job);
    endtask

    task automatic queue_mix(input int n);
        int          pick;
        logic [47:0] a;
        logic [35:0] k;
        repeat (n) begin
            pick = $urandom_range(99);
            k    = (gen_pages > 0) ? 36'($urandom_range(gen_pages - 1)) : '0;
            a    = {16'($urandom), 32'($urandom)};
            if (pick < 40) begin
                queue_job(ACT_ALLOC, a);
            end else if (pick < 80) begin
                queue_job(ACT_FREE, (gen_pages > 0) ? {gen_base + k, 12'h000} : a);
            end else if (pick < 83) begin
                queue_job(ACT_FREE, {gen_base + 36'(gen_pages), 12'h000});
            end else if (pick < 85) begin
                queue_job(ACT_FREE, {gen_base - 36'd1, 12'h000});
            end else if (pick < 89) begin
                queue_job(ACT_FREE, {gen_base + k, 12'(a[11:0] | 12'h001)});
            end else if (pick < 93) begin
                queue_job(ACT_FREE, a);
            end else if (pick < 95) begin
                queue_job(ACT_FREE, '0);
            end else if (pick < 98) begin
                queue_job(ACT_REBUILD, a);
            end else begin
                queue_job(ACT_RSVD, a);
            end
        end
    endtask

    task automatic wait_drain();
        do @(negedge i_clk);
        while (request_q.size() != 0 || i_in_valid || reply_q.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [47:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_REGION_START) begin
            region_start_r = val;
        end else begin
            region_size_r = val;
        end
        @(negedge i_clk);
    endtask

    task automatic set_region(input logic [47:0] start, input logic [47:0] size);
        write_reg(CFG_REGION_START, start);
        write_reg(CFG_REGION_SIZE, size);
        queue_job(ACT_REBUILD, '0);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty allocator straight out of reset.
        queue_job(ACT_ALLOC, '0);
        queue_job(ACT_FREE, '0);
        queue_job(ACT_FREE, 48'h1001);
        queue_job(ACT_FREE, 48'h1000);
        queue_job(ACT_RSVD, '1);
        queue_job(ACT_REBUILD, '0);
        wait_drain();

        // Four pages at 0x2000, start rounded up and end rounded down.
        set_region(48'h1234, 48'h5000);
        repeat (5) queue_job(ACT_ALLOC, '0);
        queue_job(ACT_FREE, 48'h5000);
        queue_job(ACT_FREE, 48'h6000);
        queue_job(ACT_FREE, 48'h1000);
        queue_job(ACT_FREE, 48'h2000);
        queue_job(ACT_FREE, 48'hFFFF_FFFF_F000);
        queue_job(ACT_FREE, 48'hFFFF_FFFF_FFFF);
        wait_drain();

        // Start wraps to zero and the region saturates; the stack is full.
        set_region('1, '1);
        queue_job(ACT_FREE, 48'h1000);
        queue_job(ACT_ALLOC, '0);
        queue_job(ACT_FREE, 48'hFF_F000);
        queue_job(ACT_ALLOC, '0);
        wait_drain();

        // The receiver holds off while the sender keeps offering beats.
        set_region(48'h0012_3456_7000, 48'h40000);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (300) @(negedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        queue_mix(40);
        wait_drain();
        send_idle_pct = 68;
        queue_mix(200);
        wait_drain();
        send_idle_pct = 0;

        set_region('1, '1);
        recv_stall_pct = 68;
        queue_mix(250);
        wait_drain();
        recv_stall_pct = 0;

        set_region(48'hFFFF_FFF0_0000, 48'h0F_FFFF);
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        queue_mix(250);
        wait_drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // End address wraps below the start, so nothing is managed.
        set_region(48'hFFFF_FFFF_0000, 48'h20000);
        queue_mix(20);
        wait_drain();

        set_region({16'($urandom), 32'($urandom)}, 48'($urandom_range(32'h30000)));
        queue_mix(240);
        wait_drain();

        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("page_frame_free_stack_tb: clean");
        end else begin
            $display("page_frame_free_stack_tb: errors");
        end
        $finish;
    end

endmodule
